@@ rtl/nrc_pkg.sv @@
// Shared types and constants for the node range compressor.
package nrc_pkg;

  localparam int unsigned NodeWidthDefault = 16;
  localparam int unsigned PortNodeWidth    = 16;
  localparam int unsigned QueueDepth       = 2;

  typedef enum logic [1:0] {
    ENTRY_NUMBER = 2'd0,
    ENTRY_EMPTY  = 2'd1,
    ENTRY_ZERO   = 2'd2
  } entry_kind_e;

  typedef enum logic [1:0] {
    CLS_NUMBER = 2'd0,
    CLS_EMPTY  = 2'd1,
    CLS_ZERO   = 2'd2
  } item_class_e;

  typedef enum logic [1:0] {
    PIECE_SINGLE = 2'd0,
    PIECE_RANGE  = 2'd1,
    PIECE_EMPTY  = 2'd2,
    PIECE_ZERO   = 2'd3
  } piece_kind_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } run_dir_e;

  typedef struct packed {
    item_class_e cls;
    logic        last;
  } item_ctrl_t;

  localparam int unsigned ItemCtrlWidth = $bits(item_ctrl_t);

endpackage

@@ rtl/nrc_front.sv @@
// Front end: input handshake and classification of each entry.
module nrc_front #(
  parameter int unsigned NODE_WIDTH = nrc_pkg::NodeWidthDefault
) (
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [nrc_pkg::PortNodeWidth-1:0]     node_number_i,
  input  logic [1:0]                            entry_kind_i,
  input  logic                                  end_of_list_i,
  input  logic                                  queue_full_i,
  output logic                                  push_o,
  output logic [NODE_WIDTH-1:0]                 node_o,
  output nrc_pkg::item_ctrl_t                   ctrl_o
);

  logic [NODE_WIDTH-1:0] node;

  if (NODE_WIDTH <= nrc_pkg::PortNodeWidth) begin : g_node_trunc
    assign node = node_number_i[NODE_WIDTH-1:0];
  end else begin : g_node_ext
    assign node = {{(NODE_WIDTH - nrc_pkg::PortNodeWidth){1'b0}}, node_number_i};
  end

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;
  assign node_o     = node;

  always_comb begin
    ctrl_o.last = end_of_list_i;
    unique case (nrc_pkg::entry_kind_e'(entry_kind_i))
      nrc_pkg::ENTRY_NUMBER: begin
        ctrl_o.cls = (node == '0) ? nrc_pkg::CLS_ZERO : nrc_pkg::CLS_NUMBER;
      end
      nrc_pkg::ENTRY_ZERO:  ctrl_o.cls = nrc_pkg::CLS_ZERO;
      nrc_pkg::ENTRY_EMPTY: ctrl_o.cls = nrc_pkg::CLS_EMPTY;
      default:              ctrl_o.cls = nrc_pkg::CLS_EMPTY;
    endcase
  end

endmodule

@@ rtl/nrc_queue.sv @@
// Two-entry queue between the front end and the run engine.
module nrc_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned Depth = nrc_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [WIDTH-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/nrc_back.sv @@
// Run engine: tracks the open run and issues pieces through an output register.
module nrc_back #(
  parameter int unsigned NODE_WIDTH = nrc_pkg::NodeWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  nrc_pkg::item_ctrl_t   head_ctrl_i,
  input  logic [NODE_WIDTH-1:0] head_node_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            piece_kind_o,
  output logic [NODE_WIDTH-1:0] range_first_o,
  output logic [NODE_WIDTH-1:0] range_final_o,
  output logic                  list_done_o
);

  logic                  run_open_q, run_open_d;
  logic [NODE_WIDTH-1:0] run_start_q, run_start_d;
  logic [NODE_WIDTH-1:0] run_latest_q, run_latest_d;
  nrc_pkg::run_dir_e     run_dir_q, run_dir_d;
  logic                  phase_q, phase_d;

  logic                  out_valid_q, out_valid_d;
  nrc_pkg::piece_kind_e  out_kind_q;
  logic [NODE_WIDTH-1:0] out_first_q, out_final_q;
  logic                  out_done_q;

  logic [NODE_WIDTH:0]   latest_up;
  logic                  is_up, is_down, cont;

  logic                  pre_valid, post_valid;
  nrc_pkg::piece_kind_e  pre_kind, post_kind;
  logic [NODE_WIDTH-1:0] pre_first, pre_final, post_first, post_final;

  logic                  out_free, load, advance, emit_pre;

  // one bit wider than the node, so the top value never steps up
  assign latest_up = {1'b0, run_latest_q} + {{NODE_WIDTH{1'b0}}, 1'b1};
  assign is_up     = ({1'b0, head_node_i} == latest_up);
  assign is_down   = (run_latest_q != '0) && (head_node_i == run_latest_q - NODE_WIDTH'(1));
  assign cont      = (run_dir_q == nrc_pkg::DIR_UP) ? is_up : is_down;

  always_comb begin
    run_open_d   = run_open_q;
    run_start_d  = run_start_q;
    run_latest_d = run_latest_q;
    run_dir_d    = run_dir_q;
    pre_valid    = 1'b0;
    pre_kind     = nrc_pkg::PIECE_SINGLE;
    pre_first    = run_start_q;
    pre_final    = run_start_q;
    post_valid   = 1'b0;
    post_kind    = nrc_pkg::PIECE_SINGLE;
    post_first   = '0;
    post_final   = '0;
    unique case (head_ctrl_i.cls)
      nrc_pkg::CLS_NUMBER: begin
        if (!run_open_q) begin
          run_open_d   = 1'b1;
          run_start_d  = head_node_i;
          run_latest_d = head_node_i;
          run_dir_d    = nrc_pkg::DIR_NONE;
        end else begin
          run_latest_d = head_node_i;
          unique case (run_dir_q)
            nrc_pkg::DIR_NONE: begin
              priority if (is_up) begin
                run_dir_d = nrc_pkg::DIR_UP;
              end else if (is_down) begin
                run_dir_d = nrc_pkg::DIR_DOWN;
              end else begin
                pre_valid   = 1'b1;
                run_start_d = head_node_i;
              end
            end
            nrc_pkg::DIR_UP, nrc_pkg::DIR_DOWN: begin
              if (!cont) begin
                pre_valid   = 1'b1;
                pre_kind    = nrc_pkg::PIECE_RANGE;
                pre_final   = run_latest_q;
                run_start_d = head_node_i;
                run_dir_d   = nrc_pkg::DIR_NONE;
              end
            end
            default: ;
          endcase
        end
        if (head_ctrl_i.last) begin
          post_valid   = 1'b1;
          post_kind    = (run_dir_d == nrc_pkg::DIR_NONE) ? nrc_pkg::PIECE_SINGLE
                                                          : nrc_pkg::PIECE_RANGE;
          post_first   = run_start_d;
          post_final   = run_latest_d;
          run_open_d   = 1'b0;
          run_start_d  = '0;
          run_latest_d = '0;
          run_dir_d    = nrc_pkg::DIR_NONE;
        end
      end
      nrc_pkg::CLS_EMPTY, nrc_pkg::CLS_ZERO: begin
        pre_valid    = run_open_q;
        pre_kind     = (run_dir_q == nrc_pkg::DIR_NONE) ? nrc_pkg::PIECE_SINGLE
                                                        : nrc_pkg::PIECE_RANGE;
        pre_final    = run_latest_q;
        post_valid   = 1'b1;
        post_kind    = (head_ctrl_i.cls == nrc_pkg::CLS_ZERO) ? nrc_pkg::PIECE_ZERO
                                                              : nrc_pkg::PIECE_EMPTY;
        run_open_d   = 1'b0;
        run_start_d  = '0;
        run_latest_d = '0;
        run_dir_d    = nrc_pkg::DIR_NONE;
      end
      default: ;
    endcase
  end

  // an entry with two pieces takes two output slots; state moves on the second
  assign out_free = !out_valid_q || out_ready_i;
  assign emit_pre = pre_valid && !phase_q;

  always_comb begin
    load    = 1'b0;
    advance = 1'b0;
    phase_d = phase_q;
    if (head_valid_i) begin
      if (!pre_valid && !post_valid) begin
        advance = 1'b1;
      end else if (out_free) begin
        load = 1'b1;
        if (pre_valid && post_valid && !phase_q) begin
          phase_d = 1'b1;
        end else begin
          advance = 1'b1;
          phase_d = 1'b0;
        end
      end
    end
  end

  assign pop_o = advance;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q   <= 1'b0;
      run_start_q  <= '0;
      run_latest_q <= '0;
      run_dir_q    <= nrc_pkg::DIR_NONE;
      phase_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        run_open_q   <= run_open_d;
        run_start_q  <= run_start_d;
        run_latest_q <= run_latest_d;
        run_dir_q    <= run_dir_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q  <= emit_pre ? pre_kind : post_kind;
      out_first_q <= emit_pre ? pre_first : post_first;
      out_final_q <= emit_pre ? pre_final : post_final;
      out_done_q  <= !emit_pre && head_ctrl_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign piece_kind_o  = out_kind_q;
  assign range_first_o = out_first_q;
  assign range_final_o = out_final_q;
  assign list_done_o   = out_done_q;

endmodule

@@ rtl/node_range_compressor.sv @@
// Node range compressor top level: front end, queue and run engine.
//
// Input channel (in_valid_i/in_ready_o) carries one list entry per transaction:
// a node number, an entry kind and an end-of-list flag. Output channel
// (out_valid_o/out_ready_i) carries one piece per transaction: a single node,
// a first-final range, or an empty/zero marker, with list_done_o on the last
// piece that an end-of-list entry produces.
// An accepted entry is written into the queue; the piece it completes is then
// loaded into the output register. Throughput: one entry per cycle while each
// entry yields at most one piece and the receiver takes pieces; an entry that
// yields two pieces (a separator after an open run or a run break on the final
// entry) holds the run engine; the output register issues one piece per cycle.
// A two-entry queue sits between the front end and the run engine, so entries
// keep being accepted while a piece waits in the output register. When the
// receiver stalls, the output holds and the queue fills; in_ready_o drops once
// both queue entries are in use.
// Reset clears the open run, the queue and the output valid flag.
module node_range_compressor #(
  parameter int unsigned NODE_WIDTH = nrc_pkg::NodeWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [nrc_pkg::PortNodeWidth-1:0] node_number_i,
  input  logic [1:0]                        entry_kind_i,
  input  logic                              end_of_list_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        piece_kind_o,
  output logic [nrc_pkg::PortNodeWidth-1:0] range_first_o,
  output logic [nrc_pkg::PortNodeWidth-1:0] range_final_o,
  output logic                              list_done_o
);

  localparam int unsigned EntryWidth = nrc_pkg::ItemCtrlWidth + NODE_WIDTH;

  logic                  queue_full, push, head_valid, pop;
  logic [NODE_WIDTH-1:0] front_node, head_node;
  nrc_pkg::item_ctrl_t   front_ctrl, head_ctrl;
  logic [EntryWidth-1:0] queue_in, queue_out;
  logic [NODE_WIDTH-1:0] first_int, final_int;

  nrc_front #(
    .NODE_WIDTH(NODE_WIDTH)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .node_number_i(node_number_i),
    .entry_kind_i (entry_kind_i),
    .end_of_list_i(end_of_list_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .node_o       (front_node),
    .ctrl_o       (front_ctrl)
  );

  assign queue_in = {front_ctrl, front_node};

  nrc_queue #(
    .WIDTH(EntryWidth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (queue_in),
    .full_o (queue_full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .data_o (queue_out)
  );

  assign head_ctrl = nrc_pkg::item_ctrl_t'(queue_out[EntryWidth-1:NODE_WIDTH]);
  assign head_node = queue_out[NODE_WIDTH-1:0];

  nrc_back #(
    .NODE_WIDTH(NODE_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_ctrl_i  (head_ctrl),
    .head_node_i  (head_node),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .piece_kind_o (piece_kind_o),
    .range_first_o(first_int),
    .range_final_o(final_int),
    .list_done_o  (list_done_o)
  );

  if (NODE_WIDTH >= nrc_pkg::PortNodeWidth) begin : g_out_trunc
    assign range_first_o = first_int[nrc_pkg::PortNodeWidth-1:0];
    assign range_final_o = final_int[nrc_pkg::PortNodeWidth-1:0];
  end else begin : g_out_ext
    assign range_first_o = {{(nrc_pkg::PortNodeWidth - NODE_WIDTH){1'b0}}, first_int};
    assign range_final_o = {{(nrc_pkg::PortNodeWidth - NODE_WIDTH){1'b0}}, final_int};
  end

endmodule

@@ rtl/nrc_checker.sv @@
// Port-level checks for the node range compressor, bound to the top level.
module nrc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [nrc_pkg::PortNodeWidth-1:0] node_number_i,
  input logic [1:0]                        entry_kind_i,
  input logic                              end_of_list_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [1:0]                        piece_kind_o,
  input logic [nrc_pkg::PortNodeWidth-1:0] range_first_o,
  input logic [nrc_pkg::PortNodeWidth-1:0] range_final_o,
  input logic                              list_done_o
);

  logic is_marker;

  assign is_marker = (piece_kind_o == nrc_pkg::PIECE_EMPTY) ||
                     (piece_kind_o == nrc_pkg::PIECE_ZERO);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(node_number_i) &&
      $stable(entry_kind_i) && $stable(end_of_list_i))
    else $error("input transaction changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(piece_kind_o) &&
      $stable(range_first_o) && $stable(range_final_o) && $stable(list_done_o))
    else $error("output transaction changed while stalled");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_marker |-> range_first_o == '0 && range_final_o == '0)
    else $error("marker piece carries node values");

  a_single_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && piece_kind_o == nrc_pkg::PIECE_SINGLE |-> range_first_o == range_final_o)
    else $error("single piece with differing ends");

  a_range_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && piece_kind_o == nrc_pkg::PIECE_RANGE |-> range_first_o != range_final_o)
    else $error("range piece with equal ends");

endmodule

bind node_range_compressor nrc_checker u_nrc_checker (.*);
